// ===== hw/rtl/nbh_pkg.sv =====
// Shared types and constants for the name bucket hash block.
`timescale 1ns / 1ps

package nbh_pkg;

  localparam int unsigned SUM_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0] TABLE_SIZE_RESET = SUM_W'(1021);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CASE_INSENSITIVE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE       = CFG_IDX_W'(1);

  // ASCII upper case range and the offset to lower case.
  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

  typedef logic [SUM_W-1:0] sum_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/name_bucket_hash_top.sv =====
// Top level of the name bucket hash: configuration registers and the two parts.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    in_name_byte[7:0], in_last_byte
//  out_     output     out_valid / out_stall  out_bucket_index[15:0], out_folded_sum[15:0]
//  cfg_     input      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// Name bytes are taken one per cycle while the queue is not full; the front
// folds case and updates the end-around-carry sum in the cycle the item is
// accepted. Each finished name waits in a short queue and then passes through
// the back part: a load, the bit-serial remainder, then presenting the result.
// The back part takes a new sum only after the last result has left; bytes
// stall only when the queue is full.
// Reset is synchronous and active low; it clears the running sum, the queue
// and the back state, and restores the register defaults.
// A stalled result holds in the output register while the front keeps going until the queue is full.

module name_bucket_hash_top #(
  parameter int unsigned QUEUE_DEPTH = nbh_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nbh_pkg::BYTE_W-1:0]      in_name_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nbh_pkg::SUM_W-1:0]       out_bucket_index,
  output logic [nbh_pkg::SUM_W-1:0]       out_folded_sum,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nbh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nbh_pkg::*;

  logic      case_insensitive_r;
  sum_t      table_size_r;
  logic      push;
  sum_t      push_sum;
  logic      pop;
  sum_t      pop_sum;
  q_status_t q_status;

  // Registers are always writable; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_insensitive_r <= 1'b0;
      table_size_r       <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CASE_INSENSITIVE: case_insensitive_r <= cfg_data[0];
        REG_TABLE_SIZE:       table_size_r       <= cfg_data[SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front accumulates bytes and pushes the final sum of each name.
  nbh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .case_insensitive (case_insensitive_r),
    .in_valid         (in_valid),
    .in_name_byte     (in_name_byte),
    .in_last_byte     (in_last_byte),
    .in_stall         (in_stall),
    .q_status         (q_status),
    .push             (push),
    .push_sum         (push_sum)
  );

  nbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_sum (push_sum),
    .pop      (pop),
    .pop_sum  (pop_sum),
    .q_status (q_status)
  );

  // The back reduces each sum modulo the table size and holds the result.
  nbh_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .table_size       (table_size_r),
    .q_status         (q_status),
    .pop_sum          (pop_sum),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_folded_sum   (out_folded_sum)
  );

  // A finished name is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
    else $error("name sum pushed into a full queue");

  // The back never takes a sum from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
    else $error("sum popped from an empty queue");

  // An accepted last byte leaves a sum waiting in the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> !q_status.empty)
    else $error("last byte accepted but no sum queued");

endmodule

// ===== hw/rtl/nbh_front.sv =====
// Front part: case folding and the end-around-carry accumulator over name bytes.
`timescale 1ns / 1ps

module nbh_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       case_insensitive,
  input  logic                       in_valid,
  input  logic [nbh_pkg::BYTE_W-1:0] in_name_byte,
  input  logic                       in_last_byte,
  output logic                       in_stall,
  input  nbh_pkg::q_status_t         q_status,
  output logic                       push,
  output nbh_pkg::sum_t              push_sum
);
  import nbh_pkg::*;

  sum_t               sum_r;
  sum_t               sum_nxt;
  logic [BYTE_W-1:0]  byte_fold;
  logic [SUM_W+1:0]   raw;
  logic [SUM_W:0]     fold1;
  logic [SUM_W-1:0]   fold2;
  logic               accept;

  // A whole name may stall only at its last byte, but stalling on a full
  // queue for every byte keeps the handshake independent of the payload.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    byte_fold = in_name_byte;
    if (case_insensitive && (in_name_byte >= ASCII_UPPER_A) &&
        (in_name_byte <= ASCII_UPPER_Z)) begin
      byte_fold = in_name_byte + ASCII_CASE_OFS;
    end
  end

  // Doubling plus a byte carries at most two into bit 16; after adding it
  // back a second carry can only leave a value of at most one.
  assign raw   = {1'b0, sum_r, 1'b0} + {{(SUM_W-6){1'b0}}, byte_fold};
  assign fold1 = {1'b0, raw[SUM_W-1:0]} + {{(SUM_W-1){1'b0}}, raw[SUM_W+1:SUM_W]};
  assign fold2 = fold1[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, fold1[SUM_W]};

  assign push     = accept && in_last_byte;
  assign push_sum = fold2;

  always_comb begin
    sum_nxt = sum_r;
    if (accept) begin
      sum_nxt = in_last_byte ? '0 : fold2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hw/rtl/nbh_queue.sv =====
// Short queue of finished sums between the front and back parts.
`timescale 1ns / 1ps

module nbh_queue #(
  parameter int unsigned DEPTH = nbh_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nbh_pkg::sum_t      push_sum,
  input  logic               pop,
  output nbh_pkg::sum_t      pop_sum,
  output nbh_pkg::q_status_t q_status
);
  import nbh_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sum_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_sum        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/nbh_back.sv =====
// Back part: bit-serial modulo by the table size and the result register.
`timescale 1ns / 1ps

module nbh_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nbh_pkg::sum_t           table_size,
  input  nbh_pkg::q_status_t      q_status,
  input  nbh_pkg::sum_t           pop_sum,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [nbh_pkg::SUM_W-1:0] out_bucket_index,
  output logic [nbh_pkg::SUM_W-1:0] out_folded_sum
);
  import nbh_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r;
  sum_t              dvd_r;
  sum_t              divisor_r;
  sum_t              rem_r;
  sum_t              sum_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  assign pop       = (state_r == ST_IDLE) && !q_status.empty;
  assign out_valid = (state_r == ST_DONE);
  assign out_folded_sum = sum_r;
  // A zero table size passes the sum through.
  assign out_bucket_index = (divisor_r == '0) ? sum_r : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_DIV;
            step_r  <= STEP_W'(SUM_W - 1);
          end
        end
        ST_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r     <= pop_sum;
      sum_r     <= pop_sum;
      divisor_r <= table_size;
      rem_r     <= '0;
    end else if (state_r == ST_DIV) begin
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      rem_r <= rem_sub[SUM_W] ? rem_sh[SUM_W-1:0] : rem_sub[SUM_W-1:0];
    end
  end

endmodule

// ===== verif/name_bucket_hash_checker.sv =====
// Checker for the name bucket hash: predicts each bucket result and compares it.
`timescale 1ns / 1ps

module name_bucket_hash_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [nbh_pkg::BYTE_W-1:0]      in_name_byte,
  input  logic                            in_last_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [nbh_pkg::SUM_W-1:0]       out_bucket_index,
  input  logic [nbh_pkg::SUM_W-1:0]       out_folded_sum,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [nbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nbh_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count,
  output int unsigned                     names_checked,
  output int unsigned                     bytes_seen
);

  localparam logic [31:0] SUM_MASK = 32'h0000_FFFF;

  typedef struct packed {
    nbh_pkg::sum_t bucket;
    nbh_pkg::sum_t sum;
  } bucket_result_t;

  logic           case_fold_on;
  nbh_pkg::sum_t  bucket_count;
  nbh_pkg::sum_t  running_sum;
  bucket_result_t pending_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    names_checked = 0;
    bytes_seen    = 0;
  end

  function automatic logic [nbh_pkg::BYTE_W-1:0] fold_upper(
    input logic                       fold_on,
    input logic [nbh_pkg::BYTE_W-1:0] b
  );
    if (fold_on && b >= nbh_pkg::ASCII_UPPER_A && b <= nbh_pkg::ASCII_UPPER_Z) begin
      return b + nbh_pkg::ASCII_CASE_OFS;
    end
    return b;
  endfunction

  // Double, add the byte, then fold carries back in until the value fits.
  function automatic nbh_pkg::sum_t shift_add_wrap(
    input nbh_pkg::sum_t              sum,
    input logic [nbh_pkg::BYTE_W-1:0] b
  );
    logic [31:0] acc;
    acc = (32'(sum) << 1) + 32'(b);
    while (acc > SUM_MASK) begin
      acc = (acc & SUM_MASK) + (acc >> nbh_pkg::SUM_W);
    end
    return acc[nbh_pkg::SUM_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bucket_result_t want;
    nbh_pkg::sum_t  next_sum;
    if (!rst_n) begin
      case_fold_on = 1'b0;
      bucket_count = nbh_pkg::TABLE_SIZE_RESET;
      running_sum  = '0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result bucket %0d sum %0d",
                                    out_bucket_index, out_folded_sum));
        end else begin
          want = pending_results.pop_front();
          names_checked++;
          if (out_bucket_index !== want.bucket) begin
            report_mismatch($sformatf("bucket_index got %0d expected %0d",
                                      out_bucket_index, want.bucket));
          end
          if (out_folded_sum !== want.sum) begin
            report_mismatch($sformatf("folded_sum got %0d expected %0d",
                                      out_folded_sum, want.sum));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nbh_pkg::REG_CASE_INSENSITIVE: case_fold_on = cfg_data[0];
          nbh_pkg::REG_TABLE_SIZE:       bucket_count = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        bytes_seen++;
        next_sum = shift_add_wrap(running_sum, fold_upper(case_fold_on, in_name_byte));
        if (in_last_byte) begin
          want.sum    = next_sum;
          want.bucket = (bucket_count != 0) ? next_sum % bucket_count : next_sum;
          pending_results.push_back(want);
          running_sum = '0;
        end else begin
          running_sum = next_sum;
        end
      end
    end
    pending_count = pending_results.size();
  end

endmodule

// ===== verif/tb_name_bucket_hash_top.sv =====
// Testbench top for the name bucket hash: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_name_bucket_hash_top;

  // This settle time after the last result covers anything still moving in the
  // back part before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Length of the long receiver hold-off that fills the result queue.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned QUIET_LIMIT   = 5000;

  // Register indexes that no register decodes; writes to them must be ignored.
  localparam logic [nbh_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [nbh_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  // Flavors of random name content.
  typedef enum int {MIX_ANY, MIX_LETTERS, MIX_CASE_EDGES, MIX_HIGH} byte_mix_e;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [nbh_pkg::BYTE_W-1:0]     in_name_byte = '0;
  logic                           in_last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic [nbh_pkg::SUM_W-1:0]      out_bucket_index;
  logic [nbh_pkg::SUM_W-1:0]      out_folded_sum;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [nbh_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [nbh_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned names_checked;
  int unsigned bytes_seen;

  // Idle rates in percent for the sender and the receiver, set per phase.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned reg_writes        = 0;

  // A toggle on hold_go asks the receiver process for one long hold-off.
  logic        hold_go   = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  name_bucket_hash_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_name_byte     (in_name_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_folded_sum   (out_folded_sum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  name_bucket_hash_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_name_byte     (in_name_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_folded_sum   (out_folded_sum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .names_checked    (names_checked),
    .bytes_seen       (bytes_seen)
  );

  // Receiver side. A requested hold-off keeps the stall high for a fixed count
  // of cycles; otherwise the stall follows the random rate of the phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_go;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: the run is hung if no channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one name byte, idling first at the phase rate, and return right after
  // the edge that accepts it. The valid stays high into the next call so that
  // back-to-back bytes are never split by a dropped valid.
  task automatic send_byte(input logic [nbh_pkg::BYTE_W-1:0] b, input logic last);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_name_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every expected result has come back, then let the back part
  // settle so that a register write cannot land under a name still in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(
    input logic [nbh_pkg::CFG_IDX_W-1:0]  idx,
    input logic [nbh_pkg::CFG_DATA_W-1:0] data
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(input logic fold_on, input logic [nbh_pkg::SUM_W-1:0] buckets);
    // Only bit 0 of the case register counts; the upper bits carry noise.
    write_reg(nbh_pkg::REG_CASE_INSENSITIVE, {15'($urandom), fold_on});
    write_reg(nbh_pkg::REG_TABLE_SIZE, buckets);
  endtask

  // Send whole names until at least n_bytes bytes went out. Most names are
  // short, a few are long enough to exercise repeated end-around carries.
  task automatic send_random_names(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    byte_mix_e   mix;
    logic [nbh_pkg::BYTE_W-1:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      mix = byte_mix_e'($urandom_range(3));
      for (int unsigned i = 0; i < len; i++) begin
        case (mix)
          MIX_LETTERS: begin
            b = 8'($urandom_range(nbh_pkg::ASCII_UPPER_Z, nbh_pkg::ASCII_UPPER_A));
            if ($urandom_range(1) == 1) b = b + nbh_pkg::ASCII_CASE_OFS;
          end
          MIX_CASE_EDGES: begin
            // Bytes just outside and on the borders of the letter ranges.
            case ($urandom_range(3))
              0: b = 8'(nbh_pkg::ASCII_UPPER_A - 1);
              1: b = 8'(nbh_pkg::ASCII_UPPER_Z + 1);
              2: b = nbh_pkg::ASCII_UPPER_A;
              default: b = nbh_pkg::ASCII_UPPER_Z;
            endcase
            if ($urandom_range(1) == 1) b = b + nbh_pkg::ASCII_CASE_OFS;
          end
          MIX_HIGH: b = ($urandom_range(1) == 1) ? 8'hFF : 8'($urandom_range(255, 128));
          default:  b = 8'($urandom_range(255));
        endcase
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names under the reset settings: all-zero and all-one single
    // bytes as one-byte names, a mixed-case pair that must not be folded, and
    // a run of 0xFF bytes that keeps producing carries out of bit 15.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(nbh_pkg::ASCII_UPPER_A, 1'b0);
    send_byte(8'h7A, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);
    drain_results();

    // Case folding on with the largest table. The two writes to undecoded
    // indexes must change nothing; a decoder that aliased them onto the real
    // registers would clear the folding or zero the table size.
    set_config(1'b1, 16'hFFFF);
    write_reg(REG_UNUSED_LO, 16'h0000);
    write_reg(REG_UNUSED_HI, 16'h0000);
    send_byte(8'(nbh_pkg::ASCII_UPPER_A - 1), 1'b0);
    send_byte(nbh_pkg::ASCII_UPPER_A, 1'b0);
    send_byte(nbh_pkg::ASCII_UPPER_Z, 1'b0);
    send_byte(8'(nbh_pkg::ASCII_UPPER_Z + 1), 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h7A, 1'b1);
    send_byte(8'h80, 1'b1);
    drain_results();

    // A zero table size is out of range; the bucket then equals the sum.
    write_reg(nbh_pkg::REG_TABLE_SIZE, 16'h0000);
    send_byte(nbh_pkg::ASCII_UPPER_Z, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    drain_results();

    // Random names, first with a slow sender and a slower receiver.
    sender_idle_pct    = 35;
    receiver_stall_pct <= 49;
    set_config(1'b1, 16'hFFFF);
    send_random_names(100);
    drain_results();

    // Roles swapped; a table of one bucket, then a random size.
    sender_idle_pct    = 49;
    receiver_stall_pct <= 35;
    set_config(1'b0, 16'd1);
    send_random_names(60);
    drain_results();
    set_config(1'b1, 16'($urandom_range(65534, 2)));
    send_random_names(60);
    drain_results();

    // No idling. The receiver holds off for a long stretch at the start while
    // the sender keeps offering names, so the result queue fills and the input
    // side has to stall.
    sender_idle_pct    = 0;
    receiver_stall_pct <= 0;
    set_config(1'b0, 16'h0000);
    hold_go <= ~hold_go;
    send_random_names(60);
    drain_results();
    set_config(1'b1, 16'($urandom_range(16, 2)));
    send_random_names(120);
    drain_results();

    $display("summary: %0d name bytes hashed, %0d names checked, %0d register writes",
             bytes_seen, names_checked, reg_writes);
    $display("summary: case folding on and off, table sizes 0, 1, 1021, 65535 and random");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nbh_pkg.sv
hw/rtl/nbh_front.sv
hw/rtl/nbh_queue.sv
hw/rtl/nbh_back.sv
hw/rtl/name_bucket_hash_top.sv
verif/name_bucket_hash_checker.sv
verif/tb_name_bucket_hash_top.sv
